// File: design/ufce_pkg.sv
package ufce_pkg;

  // Number of nodes in the parent table.
  localparam int NODES = 1024;
  // Width of a table entry and of a table address.
  localparam int IDX_W = $clog2(NODES);
  // Width of a node index as it arrives on the input channel and leaves on the result channel.
  localparam int IN_W = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IN_W-1:0] node_t;

  // One cycle of parent memory traffic: a read address every cycle, an optional write.
  typedef struct packed {
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    idx_t wr_data;
  } mem_req_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic  valid;
    logic  redundant;
    node_t root;
  } res_t;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_CHK,
    WK_HALVE,
    WK_DONE
  } walk_state_t;

  // Reduces an incoming index modulo NODES by restoring subtraction of NODES shifted
  // left. Steps whose shifted constant exceeds the largest index fold away.
  function automatic idx_t fold_index(node_t v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = IN_W - 1; k >= 0; k--) begin
      if (r >= (32'(NODES) << k)) begin
        r = r - (32'(NODES) << k);
      end
    end
    return IDX_W'(r);
  endfunction

endpackage

// File: design/ufce_parent_mem.sv
module ufce_parent_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  ufce_pkg::mem_req_t req,
  output ufce_pkg::idx_t    rdata,
  output logic              busy
);

  ufce_pkg::idx_t mem_r [ufce_pkg::NODES];
  ufce_pkg::idx_t rdata_r;
  ufce_pkg::idx_t clr_idx_r, clr_idx_nxt;
  logic           clr_busy_r, clr_busy_nxt;

  logic           wr_en;
  ufce_pkg::idx_t wr_addr;
  ufce_pkg::idx_t wr_data;

  // After reset the table is swept once so that every entry holds its own index.
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + ufce_pkg::IDX_W'(1);
      if (clr_idx_r == ufce_pkg::IDX_W'(ufce_pkg::NODES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign wr_en   = clr_busy_r || req.wr_en;
  assign wr_addr = clr_busy_r ? clr_idx_r : req.wr_addr;
  assign wr_data = clr_busy_r ? clr_idx_r : req.wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // Write-first forwarding keeps a same-cycle write to the read address visible.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == req.rd_addr)) begin
      rdata_r <= wr_data;
    end else begin
      rdata_r <= mem_r[req.rd_addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

  a_no_walk_write_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !req.wr_en
  ) else $error("parent table written by the walker during the clearing sweep");

endmodule

// File: design/ufce_walker.sv
module ufce_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ufce_pkg::node_t    node_a,
  input  ufce_pkg::node_t    node_b,
  input  ufce_pkg::idx_t     rdata,
  input  logic               res_take,
  output ufce_pkg::mem_req_t req,
  output ufce_pkg::res_t     res,
  output logic               idle
);

  ufce_pkg::walk_state_t st_r, st_nxt;
  ufce_pkg::idx_t        x_r, x_nxt;
  ufce_pkg::idx_t        b_r, b_nxt;
  ufce_pkg::idx_t        ra_r, ra_nxt;
  ufce_pkg::idx_t        rb_r, rb_nxt;
  logic                  phase_r, phase_nxt;
  logic                  redundant_r, redundant_nxt;
  ufce_pkg::idx_t        fa;

  assign fa = ufce_pkg::fold_index(node_a);

  // Each check reads the parent of x. A root ends the walk; otherwise the
  // grandparent is fetched and written into x's entry, and the walk moves there.
  always_comb begin
    st_nxt        = st_r;
    x_nxt         = x_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    phase_nxt     = phase_r;
    redundant_nxt = redundant_r;
    req.rd_addr   = x_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = x_r;
    req.wr_data   = rdata;
    case (st_r)
      ufce_pkg::WK_IDLE: begin
        if (start) begin
          req.rd_addr = fa;
          x_nxt       = fa;
          b_nxt       = ufce_pkg::fold_index(node_b);
          phase_nxt   = 1'b0;
          st_nxt      = ufce_pkg::WK_CHK;
        end
      end
      ufce_pkg::WK_CHK: begin
        if (rdata == x_r) begin
          if (!phase_r) begin
            ra_nxt      = x_r;
            x_nxt       = b_r;
            req.rd_addr = b_r;
            phase_nxt   = 1'b1;
          end else begin
            rb_nxt        = x_r;
            redundant_nxt = (ra_r == x_r);
            if (ra_r != x_r) begin
              req.wr_en   = 1'b1;
              req.wr_addr = ra_r;
              req.wr_data = x_r;
            end
            st_nxt = ufce_pkg::WK_DONE;
          end
        end else begin
          req.rd_addr = rdata;
          st_nxt      = ufce_pkg::WK_HALVE;
        end
      end
      ufce_pkg::WK_HALVE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = x_r;
        req.wr_data = rdata;
        req.rd_addr = rdata;
        x_nxt       = rdata;
        st_nxt      = ufce_pkg::WK_CHK;
      end
      ufce_pkg::WK_DONE: begin
        if (res_take) begin
          st_nxt = ufce_pkg::WK_IDLE;
        end
      end
      default: begin
        st_nxt = ufce_pkg::WK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ufce_pkg::WK_IDLE;
      phase_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    b_r         <= b_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    redundant_r <= redundant_nxt;
  end

  assign res.valid     = (st_r == ufce_pkg::WK_DONE);
  assign res.redundant = redundant_r;
  assign res.root      = ufce_pkg::IN_W'(rb_r);
  assign idle          = (st_r == ufce_pkg::WK_IDLE);

  // The table stays a forest, so no write ever makes an entry point at itself.
  a_no_self_parent_write: assert property (
    @(posedge clk) disable iff (!rst_n) req.wr_en |-> (req.wr_addr != req.wr_data)
  ) else $error("parent write would create a self loop");

  a_start_enters_walk: assert property (
    @(posedge clk) disable iff (!rst_n)
    (st_r == ufce_pkg::WK_IDLE && start) |=> (st_r == ufce_pkg::WK_CHK && !phase_r)
  ) else $error("accepted edge did not start the first walk");

  a_result_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    (st_r == ufce_pkg::WK_DONE && !res_take) |=>
      (st_r == ufce_pkg::WK_DONE && $stable(rb_r) && $stable(redundant_r))
  ) else $error("finished result changed before it was taken");

endmodule

// File: design/union_find_cycle_edge_classifier_unit.sv
// Union-find edge classifier with path halving. Each input beat carries one edge
// (node_a, node_b); indices at or above the node count are reduced modulo it. The
// block walks to the root of node_a and then of node_b in a parent table kept in a
// single on-chip memory, writing each grandparent shortcut back as it goes. If the
// roots differ, the first root is linked under the second and the edge is reported
// as a spanning-tree edge (redundant = 0); if they match, it is reported as closing
// a cycle (redundant = 1). root_out is always the root found for node_b. Exactly one
// result beat leaves per input beat, in order. The parent table has a single read port
// with a registered output, and each halving step on either walk needs one read of the
// parent and one of the grandparent. One edge is in flight at a time, and the next is
// accepted once the current result has moved into the output register. After reset
// the table is swept to the identity, one entry per cycle, and in_stall stays high
// until the sweep is done.
module union_find_cycle_edge_classifier_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufce_pkg::node_t     in_node_a,
  input  ufce_pkg::node_t     in_node_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_redundant,
  output ufce_pkg::node_t     out_root_out
);

  ufce_pkg::mem_req_t req;
  ufce_pkg::idx_t     rdata;
  ufce_pkg::res_t     res;
  logic               mem_busy;
  logic               walk_idle;
  logic               in_accept;
  logic               res_take;

  logic               out_valid_r, out_valid_nxt;
  logic               out_redundant_r;
  ufce_pkg::node_t    out_root_r;

  ufce_parent_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata),
    .busy  (mem_busy)
  );

  ufce_walker u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .node_a   (in_node_a),
    .node_b   (in_node_b),
    .rdata    (rdata),
    .res_take (res_take),
    .req      (req),
    .res      (res),
    .idle     (walk_idle)
  );

  // New edges wait for the clearing sweep and for the sequencer to be free.
  assign in_stall  = mem_busy || !walk_idle;
  assign in_accept = in_valid && !in_stall;

  // The output register takes a result when it is empty or its beat leaves this cycle.
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_redundant_r <= res.redundant;
      out_root_r      <= res.root;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_redundant = out_redundant_r;
  assign out_root_out  = out_root_r;

  // A result beat appears only after the sequencer has finished an edge.
  a_out_from_result: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(res.valid)
  ) else $error("result beat raised without a finished edge");

endmodule

// File: tb/sv/union_find_cycle_edge_classifier_unit_tb.sv
module union_find_cycle_edge_classifier_unit_tb;
  import ufce_pkg::*;

  // Length of the forced receiver hold-off in the backpressure test, in cycles.
  localparam int LONG_HOLD = 400;
  // Quiet cycles allowed after the last expected beat before the verdict is printed.
  localparam int DRAIN_CYCLES = 64;
  // How many past edges are kept around for replay as known cycle closers.
  localparam int EDGE_LOG_DEPTH = 512;

  // One expected result beat: the cycle flag and the root of the second endpoint.
  typedef struct packed {
    logic  redundant;
    node_t root;
  } verdict_t;

  typedef struct packed {
    node_t a;
    node_t b;
  } edge_pair_t;

  // Shapes of randomly drawn edges. Each one steers the union-find state differently.
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_LOCAL,
    SHAPE_REPEAT,
    SHAPE_SELF,
    SHAPE_EXTREME
  } edge_shape_t;

  // Every input is given a known value from time zero on.
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  node_t in_node_a = '0;
  node_t in_node_b = '0;
  logic  out_stall = 1'b0;

  logic  in_stall;
  logic  out_valid;
  logic  out_redundant;
  node_t out_root_out;

  union_find_cycle_edge_classifier_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_redundant(out_redundant),
    .out_root_out (out_root_out)
  );

  always #5 clk = ~clk;

  // Shadow copy of the parent table, advanced once per accepted edge beat.
  idx_t       parent_shadow [NODES];
  // Results that the block still owes, oldest first.
  verdict_t   owed_verdicts [$];
  // Recently accepted edges. Replaying one of them must always close a cycle.
  edge_pair_t edge_log [$];

  int mismatch_count = 0;
  int result_count = 0;

  // Sender pacing: bursts of back-to-back beats, each preceded by a random gap bounded by gap_max.
  int burst_left = 0;
  int gap_max = 0;
  // Base node of the small window that local edges are drawn from.
  node_t window_base = '0;

  // The long hold-off is requested by bumping hold_requests. The stall process serves each
  // request on its own and counts the cycles itself, so no two processes write one variable.
  int hold_requests = 0;
  int hold_grants = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  // Root walk with path halving: every visited entry is pointed at its grandparent before
  // the walk jumps there. The step bound only matters if the table ever stopped being a
  // forest, which a correct sequence of links never does.
  function automatic idx_t walk_to_root(idx_t start);
    idx_t x;
    idx_t up;
    int   steps;
    x = start;
    steps = 0;
    while (parent_shadow[x] != x && steps < NODES) begin
      up = parent_shadow[x];
      parent_shadow[x] = parent_shadow[up];
      x = parent_shadow[x];
      steps++;
    end
    return x;
  endfunction

  // Classifies one edge against the shadow table and applies the link it causes. The
  // source endpoint is walked first, since its halving writes can shorten the second walk.
  function automatic verdict_t classify_edge(node_t a, node_t b);
    idx_t     root_a;
    idx_t     root_b;
    verdict_t v;
    root_a = walk_to_root(idx_t'(a % NODES));
    root_b = walk_to_root(idx_t'(b % NODES));
    if (root_a != root_b) begin
      parent_shadow[root_a] = root_b;
      v.redundant = 1'b0;
    end else begin
      v.redundant = 1'b1;
    end
    v.root = node_t'(root_b);
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Offers one edge beat and waits until the block takes it. Between bursts the sender
  // drops valid for a random gap. Valid is never lowered here once an edge is offered, so
  // back-to-back beats see exactly one assignment to in_valid per clock edge.
  task automatic send_edge(node_t a, node_t b);
    int         gap;
    verdict_t   owed;
    edge_pair_t pair;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // The beat was taken at this edge, so the table moves on in acceptance order.
    owed = classify_edge(a, b);
    owed_verdicts = {owed_verdicts, owed};
    pair.a = a;
    pair.b = b;
    edge_log = {edge_log, pair};
    if (edge_log.size() > EDGE_LOG_DEPTH) begin
      void'(edge_log.pop_front());
    end
  endtask

  // Draws one random edge. Uniform edges mostly join components, local and replayed edges
  // close cycles inside already joined regions, and the extremes keep the top and bottom
  // indices in play long after the directed part.
  function automatic edge_pair_t pick_edge();
    int          roll;
    edge_shape_t shape;
    edge_pair_t  e;
    edge_pair_t  old;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      shape = SHAPE_UNIFORM;
    end else if (roll < 65) begin
      shape = SHAPE_LOCAL;
    end else if (roll < 80) begin
      shape = SHAPE_REPEAT;
    end else if (roll < 90) begin
      shape = SHAPE_SELF;
    end else begin
      shape = SHAPE_EXTREME;
    end
    if (shape == SHAPE_REPEAT && edge_log.size() == 0) begin
      shape = SHAPE_UNIFORM;
    end
    if ($urandom_range(0, 39) == 0) begin
      window_base = node_t'($urandom());
    end
    e.a = node_t'($urandom());
    e.b = node_t'($urandom());
    case (shape)
      SHAPE_LOCAL: begin
        e.a = node_t'(window_base + $urandom_range(0, 47));
        e.b = node_t'(window_base + $urandom_range(0, 47));
      end
      SHAPE_REPEAT: begin
        old = edge_log[$urandom_range(0, edge_log.size() - 1)];
        if ($urandom_range(0, 1) == 0) begin
          e = old;
        end else begin
          e.a = old.b;
          e.b = old.a;
        end
      end
      SHAPE_SELF: begin
        e.b = e.a;
      end
      SHAPE_EXTREME: begin
        if ($urandom_range(0, 1) == 0) begin
          e.a = ($urandom_range(0, 1) == 0) ? node_t'(0) : node_t'(NODES - 1);
        end else begin
          e.b = ($urandom_range(0, 1) == 0) ? node_t'(0) : node_t'(NODES - 1);
        end
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // Receiver. The long hold-off takes priority. Otherwise the stall pattern switches
  // every so often between never stalling, light stalling and heavy stalling.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_grants != hold_requests) begin
      out_stall <= 1'b1;
      hold_grants <= hold_grants + 1;
      hold_left <= LONG_HOLD - 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result checker. Values are read in the active region of the clock edge, so both the
  // block's outputs and out_stall are the ones that were in force when the beat moved.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_count <= result_count + 1;
      if (owed_verdicts.size() == 0) begin
        report_mismatch("result beat with no edge outstanding", out_root_out, -1);
      end else begin
        want = owed_verdicts.pop_front();
        if (out_redundant !== want.redundant) begin
          report_mismatch($sformatf("beat %0d redundant", result_count),
                          out_redundant, want.redundant);
        end
        if (out_root_out !== want.root) begin
          report_mismatch($sformatf("beat %0d root_out", result_count),
                          out_root_out, want.root);
        end
      end
    end
  end

  // Self loops at both ends of the index range, a join and its reverse, two small
  // components merged, a short chain that a later walk halves, and alternating bit
  // patterns in both fields.
  task automatic test_directed();
    gap_max = 3;
    send_edge(10'd0, 10'd0);
    send_edge(10'd1023, 10'd1023);
    send_edge(10'd0, 10'd1023);
    send_edge(10'd1023, 10'd0);
    send_edge(10'd5, 10'd6);
    send_edge(10'd6, 10'd5);
    send_edge(10'd5, 10'd0);
    send_edge(10'd10, 10'd11);
    send_edge(10'd11, 10'd12);
    send_edge(10'd12, 10'd13);
    send_edge(10'd13, 10'd14);
    send_edge(10'd14, 10'd15);
    send_edge(10'd15, 10'd16);
    send_edge(10'd10, 10'd16);
    send_edge(10'd17, 10'd10);
    send_edge(10'd16, 10'd17);
    send_edge(10'd10, 10'd5);
    send_edge(10'd682, 10'd341);
    send_edge(10'd341, 10'd682);
    send_edge(10'd512, 10'd511);
  endtask

  // Links fresh nodes one after another into a single long chain, then walks it from its
  // far end. That walk runs about a hundred halving steps and rewrites half the chain.
  task automatic test_deep_chain();
    int i;
    gap_max = 0;
    for (i = 200; i < 399; i++) begin
      send_edge(node_t'(i), node_t'(i + 1));
    end
    send_edge(10'd200, 10'd399);
    send_edge(10'd399, 10'd200);
    send_edge(10'd250, 10'd1023);
  endtask

  // Random edges, with the sender's gap length changed every so often so that both
  // back-to-back stretches and sparse stretches occur.
  task automatic test_random_edges(int count);
    int         i;
    edge_pair_t e;
    for (i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 2;
          default: gap_max = 10;
        endcase
      end
      e = pick_edge();
      send_edge(e.a, e.b);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering beats with
  // no gaps, so the output register fills, the edge in flight parks behind it, and the
  // block has to hold in_stall high until the receiver lets go.
  task automatic test_backpressure();
    int         i;
    edge_pair_t e;
    gap_max = 0;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 80; i++) begin
      e = pick_edge();
      send_edge(e.a, e.b);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NODES; i++) begin
      parent_shadow[i] = idx_t'(i);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // The block sweeps its table after reset. The first send simply waits that out.
    test_directed();
    test_deep_chain();
    test_random_edges(1000);
    test_backpressure();
    test_random_edges(120);
    in_valid <= 1'b0;
    while (owed_verdicts.size() != 0) @(posedge clk);
    // Wait out the drain period so that a stray extra beat would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("union_find_cycle_edge_classifier_unit regression: pass");
    end else begin
      $display("union_find_cycle_edge_classifier_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the sweep after reset.
  initial begin
    #20000000;
    $display("union_find_cycle_edge_classifier_unit regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
design/ufce_pkg.sv
design/ufce_parent_mem.sv
design/ufce_walker.sv
design/union_find_cycle_edge_classifier_unit.sv
tb/sv/union_find_cycle_edge_classifier_unit_tb.sv
